>>> rtl/lfa_pkg.sv
package lfa_pkg;

  localparam int MAX_IDS  = 1024;
  localparam int ID_SPACE = 1024;
  localparam int ID_W     = 10;
  localparam int CFG_W    = 11;
  localparam int WORD_W   = 64;
  localparam int BIT_W    = 6;
  localparam int NWORDS   = (MAX_IDS + WORD_W - 1) / WORD_W;
  localparam int WIDX_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CNT_W    = $clog2(NWORDS + 1);
  localparam int EFF_MAX  = (MAX_IDS < ID_SPACE) ? MAX_IDS : ID_SPACE;

  localparam logic [CFG_W-1:0] POOL_RESET = CFG_W'(1024);

  // request codes
  localparam logic [1:0] MODE_GET     = 2'd0;
  localparam logic [1:0] MODE_CHECK   = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  typedef enum logic [1:0] {
    S_FILL,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef logic [WORD_W-1:0] word_t;

  // pool size limited to what the bitmap and the id field can reach
  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] n);
    if (int'(n) > EFF_MAX) return CFG_W'(EFF_MAX);
    return n;
  endfunction

  // initial content of bitmap word w for an effective pool size n
  function automatic word_t fill_word(input logic [CFG_W-1:0] n, input int w);
    int base;
    int nn;
    base = w * WORD_W;
    nn   = int'(n);
    if (nn >= base + WORD_W) return '1;
    if (nn > base) return (word_t'(1) << (nn - base)) - word_t'(1);
    return '0;
  endfunction

  function automatic logic [NWORDS-1:0] fill_summary(input logic [CFG_W-1:0] n);
    logic [NWORDS-1:0] s;
    for (int w = 0; w < NWORDS; w++) begin
      s[w] = int'(n) > w * WORD_W;
    end
    return s;
  endfunction

  function automatic logic [BIT_W-1:0] lowest_bit(input word_t v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  function automatic logic [WIDX_W-1:0] lowest_word(input logic [NWORDS-1:0] v);
    logic [WIDX_W-1:0] r;
    r = '0;
    for (int i = NWORDS - 1; i >= 0; i--) begin
      if (v[i]) r = WIDX_W'(i);
    end
    return r;
  endfunction

endpackage

>>> rtl/lfa_if.sv
interface lfa_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               mode;
  logic [lfa_pkg::ID_W-1:0] id_number;

  modport source (output valid, output mode, output id_number, input ready);
  modport sink (input valid, input mode, input id_number, output ready);
endinterface

interface lfa_out_if;
  logic                     valid;
  logic                     ready;
  logic [lfa_pkg::ID_W-1:0] granted_id;
  logic                     granted;
  logic                     is_free;

  modport source (output valid, output granted_id, output granted, output is_free,
                  input ready);
  modport sink (input valid, input granted_id, input granted, input is_free,
                output ready);
endinterface

>>> rtl/lowest_free_id_allocator.sv
// lowest-first free id allocator
// in_ch carries one request per transaction: mode get (grant the lowest free id),
// check (report whether id_number is free) or release (free id_number, no result).
// out_ch carries one result transaction for every get and check; release and the
// unused mode code produce none. cfg_we/cfg_wdata write pool_size; a write frees
// every id below the new pool size and marks all others not free.
// ids live in a 64-bit-per-word free bitmap held in a single-port synchronous ram,
// plus a per-word nonempty summary in flops.
// requests do not overlap: a new one is taken only after the last has left the execute
// cycle. the accept cycle picks the word (lowest summary bit for get, id word otherwise)
// and reads the ram; the next cycle finds the lowest set bit, writes the word back and
// loads the result register.
// out_ch.valid is registered and rises once the execute cycle completes.
// reset (synchronous, rst_n low) and every pool_size write start a fill pass that
// rewrites each of the NWORDS bitmap words (16 at 1024 ids); in_ch.ready is low during
// the pass.
// if out_ch stalls, a new request is still taken; its write-back and result wait
// in the execute cycle until the result register drains.
module lowest_free_id_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  lfa_in_if.sink                    in_ch,
  lfa_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [lfa_pkg::CFG_W-1:0] cfg_wdata
);

  // control state
  lfa_pkg::state_t                  state_r, state_nxt;
  logic [lfa_pkg::CFG_W-1:0]        pool_size_r;
  logic [lfa_pkg::NWORDS-1:0]       summary_r, summary_nxt;
  logic [lfa_pkg::CNT_W-1:0]        fill_cnt_r, fill_cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;

  // request being executed
  logic [1:0]                       mode_r;
  logic [lfa_pkg::ID_W-1:0]         id_r;
  logic [lfa_pkg::WIDX_W-1:0]       widx_r;
  logic                             hit_r;
  lfa_pkg::word_t                   rdata_r;

  // result register
  logic [lfa_pkg::ID_W-1:0]         out_granted_id_r;
  logic                             out_granted_r;
  logic                             out_is_free_r;

  // bitmap ram
  lfa_pkg::word_t                   mem [lfa_pkg::NWORDS];
  logic                             mem_we;
  logic [lfa_pkg::WIDX_W-1:0]       mem_waddr;
  lfa_pkg::word_t                   mem_wdata;

  logic [lfa_pkg::CFG_W-1:0]        eff;
  logic                             in_ready;
  logic                             in_acc;
  logic                             id_inside;
  logic [lfa_pkg::WIDX_W-1:0]       rd_widx;
  logic                             rd_hit;

  logic [lfa_pkg::BIT_W-1:0]        sb;
  lfa_pkg::word_t                   get_word;
  lfa_pkg::word_t                   rel_word;
  logic                             is_get, is_check, is_rel;
  logic                             emit_need, exec_done;
  logic [lfa_pkg::WIDX_W+lfa_pkg::BIT_W+lfa_pkg::ID_W-1:0] grant_full;

  assign eff    = lfa_pkg::eff_size(pool_size_r);
  assign in_acc = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // request decode in the accept cycle
  assign id_inside = {1'b0, in_ch.id_number} < eff;
  always_comb begin
    if (in_ch.mode == lfa_pkg::MODE_GET) begin
      rd_widx = lfa_pkg::lowest_word(summary_r);
      rd_hit  = |summary_r;
    end else begin
      rd_widx = lfa_pkg::WIDX_W'(in_ch.id_number[lfa_pkg::ID_W-1:lfa_pkg::BIT_W]);
      rd_hit  = id_inside;
    end
  end

  // execute cycle datapath
  assign is_get    = mode_r == lfa_pkg::MODE_GET;
  assign is_check  = mode_r == lfa_pkg::MODE_CHECK;
  assign is_rel    = mode_r == lfa_pkg::MODE_RELEASE;
  assign sb        = lfa_pkg::lowest_bit(rdata_r);
  assign get_word  = rdata_r & ~(lfa_pkg::word_t'(1) << sb);
  assign rel_word  = rdata_r | (lfa_pkg::word_t'(1) << id_r[lfa_pkg::BIT_W-1:0]);
  assign emit_need = is_get || is_check;
  assign exec_done = !emit_need || !out_valid_r || out_ch.ready;
  assign grant_full = {{lfa_pkg::ID_W{1'b0}}, widx_r, sb};

  // next state, ram write and summary update
  always_comb begin
    state_nxt     = state_r;
    fill_cnt_nxt  = fill_cnt_r;
    summary_nxt   = summary_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = widx_r;
    mem_wdata     = rel_word;
    unique case (state_r)
      lfa_pkg::S_FILL: begin
        mem_we       = 1'b1;
        mem_waddr    = fill_cnt_r[lfa_pkg::WIDX_W-1:0];
        mem_wdata    = lfa_pkg::fill_word(eff, int'(fill_cnt_r));
        fill_cnt_nxt = fill_cnt_r + lfa_pkg::CNT_W'(1);
        if (fill_cnt_r == lfa_pkg::CNT_W'(lfa_pkg::NWORDS - 1)) begin
          state_nxt = lfa_pkg::S_IDLE;
        end
      end
      lfa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = lfa_pkg::S_EXEC;
        end
      end
      lfa_pkg::S_EXEC: begin
        if (exec_done) begin
          state_nxt = lfa_pkg::S_IDLE;
          if (emit_need) out_valid_nxt = 1'b1;
          if (hit_r && is_get) begin
            mem_we    = 1'b1;
            mem_wdata = get_word;
            if (get_word == '0) summary_nxt[widx_r] = 1'b0;
          end
          if (hit_r && is_rel) begin
            mem_we              = 1'b1;
            mem_wdata           = rel_word;
            summary_nxt[widx_r] = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = lfa_pkg::S_IDLE;
      end
    endcase
    // a pool size write restarts the fill pass
    if (cfg_we) begin
      state_nxt    = lfa_pkg::S_FILL;
      fill_cnt_nxt = '0;
      summary_nxt  = lfa_pkg::fill_summary(lfa_pkg::eff_size(cfg_wdata));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfa_pkg::S_FILL;
      fill_cnt_r  <= '0;
      pool_size_r <= lfa_pkg::POOL_RESET;
      summary_r   <= lfa_pkg::fill_summary(lfa_pkg::eff_size(lfa_pkg::POOL_RESET));
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      summary_r   <= summary_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) pool_size_r <= cfg_wdata;
    end
  end

  // request capture and ram read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= in_ch.mode;
      id_r    <= in_ch.id_number;
      widx_r  <= rd_widx;
      hit_r   <= rd_hit;
      rdata_r <= mem[rd_widx];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == lfa_pkg::S_EXEC && exec_done && emit_need) begin
      out_granted_r    <= is_get && hit_r;
      out_granted_id_r <= (is_get && hit_r) ? grant_full[lfa_pkg::ID_W-1:0] : '0;
      out_is_free_r    <= is_check && hit_r && rdata_r[id_r[lfa_pkg::BIT_W-1:0]];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.granted_id = out_granted_id_r;
  assign out_ch.granted    = out_granted_r;
  assign out_ch.is_free    = out_is_free_r;

  // checks
  a_no_accept_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lfa_pkg::S_FILL |-> !in_ch.ready)
    else $error("request taken during fill pass");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !cfg_we) |=> state_r == lfa_pkg::S_EXEC)
    else $error("accepted request not executed");

  a_cfg_restarts_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (state_r == lfa_pkg::S_FILL && fill_cnt_r == '0))
    else $error("pool size write did not restart fill");

  a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.granted && out_ch.is_free))
    else $error("result marks both grant and free");

  a_grant_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.granted) |-> ({1'b0, out_ch.granted_id} < eff))
    else $error("granted id outside pool");

endmodule

>>> tb/sv/lfa_grant_checker.sv
`timescale 1ns / 1ps

module lfa_grant_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  lfa_in_if                         in_ch,
  lfa_out_if                        out_ch,
  input  logic                      cfg_we,
  input  logic [lfa_pkg::CFG_W-1:0] cfg_wdata,
  output int                        failures,
  output int                        pending
);

  typedef struct packed {
    logic [lfa_pkg::ID_W-1:0] granted_id;
    logic                     granted;
    logic                     is_free;
  } alloc_result_t;

  // one flag per id, set while the id is free
  bit [lfa_pkg::EFF_MAX-1:0] free_ids;
  int                        pool_limit;
  alloc_result_t             pending_results[$];

  task refill_pool(input logic [lfa_pkg::CFG_W-1:0] size);
    pool_limit = (int'(size) > lfa_pkg::EFF_MAX) ? lfa_pkg::EFF_MAX : int'(size);
    for (int i = 0; i < lfa_pkg::EFF_MAX; i++) free_ids[i] = (i < pool_limit);
  endtask

  task apply_request(input logic [1:0] mode, input logic [lfa_pkg::ID_W-1:0] id);
    alloc_result_t r;
    bit            found;
    r     = '0;
    found = 1'b0;
    unique case (mode)
      lfa_pkg::MODE_GET: begin
        for (int i = 0; i < lfa_pkg::EFF_MAX; i++) begin
          if (!found && free_ids[i]) begin
            found        = 1'b1;
            r.granted    = 1'b1;
            r.granted_id = lfa_pkg::ID_W'(i);
            free_ids[i]  = 1'b0;
          end
        end
        pending_results.push_back(r);
      end
      lfa_pkg::MODE_CHECK: begin
        r.is_free = (int'(id) < pool_limit) && free_ids[id];
        pending_results.push_back(r);
      end
      lfa_pkg::MODE_RELEASE: begin
        if (int'(id) < pool_limit) free_ids[id] = 1'b1;
      end
      default: ;
    endcase
  endtask

  task report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    failures++;
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      refill_pool(lfa_pkg::POOL_RESET);
      pending_results.delete();
      failures = 0;
    end else begin
      if (cfg_we) refill_pool(cfg_wdata);
      if (in_ch.valid && in_ch.ready) apply_request(in_ch.mode, in_ch.id_number);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result id %0d granted %b free %b",
                                    out_ch.granted_id, out_ch.granted, out_ch.is_free));
        end else begin
          want = pending_results.pop_front();
          if (out_ch.granted_id !== want.granted_id || out_ch.granted !== want.granted ||
              out_ch.is_free !== want.is_free) begin
            report_mismatch($sformatf(
              "got id %0d granted %b free %b, expected id %0d granted %b free %b",
              out_ch.granted_id, out_ch.granted, out_ch.is_free,
              want.granted_id, want.granted, want.is_free));
          end
        end
      end
    end
    pending <= pending_results.size();
  end

endmodule

>>> tb/sv/tb_lowest_free_id_allocator.sv
`timescale 1ns / 1ps

module tb_lowest_free_id_allocator;

  // mode code the block must ignore
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // cycles with no transaction on either channel before the run is declared hung
  localparam int QUIET_LIMIT     = 1000;
  // get, check and release requests per random phase
  localparam int ITEMS_PER_PHASE = 50;
  // cycles to let a trailing release finish before touching pool_size
  localparam int DRAIN_CYCLES    = 4;
  // extra cycles after the last result before the verdict
  localparam int TAIL_CYCLES     = 8;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [lfa_pkg::CFG_W-1:0] cfg_wdata;

  bit idling;        // random gaps and stalls enabled
  int failures;      // from the checker
  int pending;       // results still owed, from the checker
  int quiet_cycles;  // watchdog count
  int out_stall;     // remaining cycles of the current result stall

  lfa_in_if  in_ch ();
  lfa_out_if out_ch ();

  lowest_free_id_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predicts every result and compares it against the result channel
  lfa_grant_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .failures  (failures),
    .pending   (pending)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // known values on every block input from time zero
  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = lfa_pkg::MODE_GET;
    in_ch.id_number = '0;
    out_ch.ready    = 1'b0;
    idling          = 1'b1;
    out_stall       = 0;
    quiet_cycles    = 0;
  end

  // result side: random stalls of out_ch.ready while idling is on
  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      out_stall    <= $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog: any transaction on either channel restarts the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // one request transaction; valid stays high into the next request unless a gap
  // is taken, so valid never gets two assignments in one step
  task automatic send_request(input logic [1:0] mode, input logic [lfa_pkg::ID_W-1:0] id);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.id_number <= id;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // drop valid and wait until every owed result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // pool_size is only written with the block idle; a release may still be in
  // flight after the last result, hence the extra drain cycles
  task automatic write_pool_size(input int size);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= lfa_pkg::CFG_W'(size);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ids mostly inside the pool, from 0 up to the pool size, so that
  // releases and checks hit ids in use; now and then any id at all
  function automatic logic [lfa_pkg::ID_W-1:0] pick_id(input int size);
    int hi;
    hi = (size > 1023) ? 1023 : size;
    if ($urandom_range(0, 3) == 0) return lfa_pkg::ID_W'($urandom_range(0, 1023));
    return lfa_pkg::ID_W'($urandom_range(0, hi));
  endfunction

  // random mix: gets drain the pool, releases refill it, checks look at it
  task automatic run_random_phase(input int size);
    int counted;
    int roll;
    write_pool_size(size);
    counted = 0;
    while (counted < ITEMS_PER_PHASE) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        send_request(lfa_pkg::MODE_GET, pick_id(size));
        counted++;
      end else if (roll < 70) begin
        send_request(lfa_pkg::MODE_CHECK, pick_id(size));
        counted++;
      end else if (roll < 95) begin
        send_request(lfa_pkg::MODE_RELEASE, pick_id(size));
        counted++;
      end else begin
        send_request(MODE_UNUSED, pick_id(size));
      end
    end
  endtask

  initial begin
    int sizes[10];
    sizes = '{64, 65, 3, 130, 1000, 2047, 1, 700, 63, 5};

    // reset once
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: full pool after reset
    send_request(lfa_pkg::MODE_GET, 10'd0);
    send_request(lfa_pkg::MODE_GET, 10'd1023);
    send_request(lfa_pkg::MODE_CHECK, 10'd0);
    send_request(lfa_pkg::MODE_CHECK, 10'd1023);
    send_request(lfa_pkg::MODE_RELEASE, 10'd0);
    send_request(lfa_pkg::MODE_CHECK, 10'd0);
    send_request(lfa_pkg::MODE_GET, 10'd0);
    send_request(lfa_pkg::MODE_RELEASE, 10'd1023);     // already free
    send_request(lfa_pkg::MODE_CHECK, 10'd1023);
    send_request(lfa_pkg::MODE_RELEASE, 10'd5);        // already free
    send_request(MODE_UNUSED, 10'd1023);               // must produce nothing
    send_request(lfa_pkg::MODE_CHECK, 10'd2);

    // one-id pool: exhaustion and out-of-pool release
    write_pool_size(1);
    send_request(lfa_pkg::MODE_GET, 10'd0);
    send_request(lfa_pkg::MODE_GET, 10'd0);            // exhausted
    send_request(lfa_pkg::MODE_CHECK, 10'd0);
    send_request(lfa_pkg::MODE_RELEASE, 10'd1);        // outside the pool
    send_request(lfa_pkg::MODE_GET, 10'd0);
    send_request(lfa_pkg::MODE_RELEASE, 10'd0);
    send_request(lfa_pkg::MODE_GET, 10'd0);

    // empty pool
    write_pool_size(0);
    send_request(lfa_pkg::MODE_GET, 10'd0);
    send_request(lfa_pkg::MODE_CHECK, 10'd0);
    send_request(lfa_pkg::MODE_RELEASE, 10'd0);
    send_request(lfa_pkg::MODE_GET, 10'd1023);

    // register value beyond the id space clamps to 1024
    write_pool_size(2047);
    send_request(lfa_pkg::MODE_CHECK, 10'd1023);
    send_request(lfa_pkg::MODE_GET, 10'd0);

    // random phases over a range of pool sizes; the last runs back to back
    foreach (sizes[p]) begin
      if (p == 9) idling = 1'b0;
      run_random_phase(sizes[p]);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
